FILE: rtl/gmps_pkg.sv
// Shared types, constants and the neighbour merge function for the
// grid max-path score counter. No dependencies.
`timescale 1ns / 1ps

package gmps_pkg;

    localparam int MaxSide = 128;
    localparam int ColW    = $clog2(MaxSide);
    localparam int CfgW    = 8;
    localparam int ValW    = 4;
    localparam int ScoreW  = 12;
    localparam int CountW  = 30;

    localparam logic [CountW-1:0] CountMod = CountW'(1000000007);
    localparam logic [ScoreW-1:0] ScoreMax = '1;

    typedef struct packed {
        logic              reach;
        logic [ScoreW-1:0] score;
        logic [CountW-1:0] count;
    } t_cell;

    // cell held between the input register and the result logic
    typedef struct packed {
        logic            valid;
        logic            last_col;
        logic            last_row;
        logic            is_end;
        logic [ColW-1:0] col;
        logic [ValW-1:0] value;
        logic            blocked;
    } t_stage;

    // row store read request issued when a word is taken
    typedef struct packed {
        logic            accept;
        logic [ColW-1:0] col;
    } t_front;

    function automatic t_cell merge(input t_cell acc, input t_cell nb);
        t_cell         res;
        logic [CountW:0] s;
        res = acc;
        s   = {1'b0, acc.count} + {1'b0, nb.count};
        if (nb.reach) begin
            if (!acc.reach || (nb.score > acc.score)) begin
                res = nb;
            end else if (nb.score == acc.score) begin
                if (s >= {1'b0, CountMod}) begin
                    s = s - {1'b0, CountMod};
                end
                res.count = s[CountW-1:0];
            end
        end
        return res;
    endfunction

    // clamped side length minus one
    function automatic logic [ColW-1:0] side_m1(input logic [CfgW-1:0] v);
        logic [ColW-1:0] res;
        if (v < CfgW'(2)) begin
            res = ColW'(1);
        end else if (int'(v) > MaxSide) begin
            res = ColW'(MaxSide - 1);
        end else begin
            res = ColW'(v - CfgW'(1));
        end
        return res;
    endfunction

endpackage

FILE: rtl/gmps_if.sv
// Valid/ready channel interfaces for cell words in and result words out.
// Uses gmps_pkg for field widths.
`timescale 1ns / 1ps

interface gmps_in_if;
    logic                     valid;
    logic                     ready;
    logic [gmps_pkg::ValW-1:0] cell_value;
    logic                     blocked;

    modport source (output valid, output cell_value, output blocked, input ready);
    modport sink   (input valid, input cell_value, input blocked, output ready);
endinterface

interface gmps_out_if;
    logic                       valid;
    logic                       ready;
    logic [gmps_pkg::ScoreW-1:0] best_score;
    logic [gmps_pkg::CountW-1:0] path_count;

    modport source (output valid, output best_score, output path_count, input ready);
    modport sink   (input valid, input best_score, input path_count, output ready);
endinterface

FILE: rtl/grid_max_path_score_counter_unit.sv
// Top level of the grid max-path score counter: wires front end and datapath
// and holds the result register. Depends on gmps_pkg, gmps_if, gmps_seq, gmps_dp.
`timescale 1ns / 1ps

// Usage:
//   i_in  carries one grid cell per word: cell_value and blocked. Cells come
//         from the bottom-right corner, right to left, rows bottom to top.
//   o_out carries one word per grid, after the top-left cell: best_score and
//         path_count (both zero when the top-left cell cannot be reached).
//   i_cfg_we / i_cfg_wdata write the grid side length (clamped to 2..128);
//         a write restarts at the bottom-right cell. Write only while idle.
// Throughput: one cell per cycle. The cycle is set by the right-neighbour
//   loop: three merges, a modulo add and a saturating score add feed the
//   right-cell register for the next cell. Row store: one read, one write.
// Result: once taken, the top-left cell waits in the input register; the
//   result register then captures its score and count.
// Reset: grid size 2, position at the bottom-right cell, no word in flight.
//   The row store needs no clearing; the bottom row never reads it.
// Stall: while a result word waits, cells keep flowing until the next grid's
//   top-left cell reaches the result stage; that cell then holds there and
//   i_in.ready drops until o_out is taken.
module grid_max_path_score_counter_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [gmps_pkg::CfgW-1:0] i_cfg_wdata,
    gmps_in_if.sink                   i_in,
    gmps_out_if.source                o_out
);

    gmps_pkg::t_front             front;
    gmps_pkg::t_stage             stage;
    gmps_pkg::t_cell              cur;
    logic                         s1_fire;
    logic                         r_o_valid;
    logic [gmps_pkg::ScoreW-1:0]  r_o_score;
    logic [gmps_pkg::CountW-1:0]  r_o_count;

    assign s1_fire = stage.valid && (!stage.is_end || !r_o_valid || o_out.ready);

    gmps_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_in.valid),
        .i_value     (i_in.cell_value),
        .i_blocked   (i_in.blocked),
        .i_s1_fire   (s1_fire),
        .o_ready     (i_in.ready),
        .o_front     (front),
        .o_stage     (stage)
    );

    gmps_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_front   (front),
        .i_stage   (stage),
        .i_s1_fire (s1_fire),
        .o_cur     (cur)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_fire && stage.is_end) begin
            r_o_valid <= 1'b1;
            r_o_score <= cur.reach ? cur.score : '0;
            r_o_count <= cur.reach ? cur.count : '0;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    assign o_out.valid      = r_o_valid;
    assign o_out.best_score = r_o_score;
    assign o_out.path_count = r_o_count;

endmodule

FILE: rtl/gmps_seq.sv
// Front end: grid size register, cell position counters and input register.
// Depends on gmps_pkg.
`timescale 1ns / 1ps

module gmps_seq (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gmps_pkg::CfgW-1:0]     i_cfg_wdata,
    input  logic                          i_valid,
    input  logic [gmps_pkg::ValW-1:0]     i_value,
    input  logic                          i_blocked,
    input  logic                          i_s1_fire,
    output logic                          o_ready,
    output gmps_pkg::t_front              o_front,
    output gmps_pkg::t_stage              o_stage
);

    logic [gmps_pkg::ColW-1:0] r_side_m1;
    logic [gmps_pkg::ColW-1:0] r_col;
    logic [gmps_pkg::ColW-1:0] r_row;
    gmps_pkg::t_stage          r_stage;
    logic                      accept;
    logic                      at_end;
    logic [gmps_pkg::ColW-1:0] n_side;

    assign o_ready = !r_stage.valid || i_s1_fire;
    assign accept  = i_valid && o_ready;
    assign at_end  = (r_row == '0) && (r_col == '0);
    assign n_side  = gmps_pkg::side_m1(i_cfg_wdata);

    assign o_front.accept = accept;
    assign o_front.col    = r_col;
    assign o_stage        = r_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_m1     <= gmps_pkg::ColW'(1);
            r_col         <= gmps_pkg::ColW'(1);
            r_row         <= gmps_pkg::ColW'(1);
            r_stage.valid <= 1'b0;
        end else begin
            if (accept) begin
                r_stage.valid    <= 1'b1;
                r_stage.col      <= r_col;
                r_stage.last_col <= (r_col == r_side_m1);
                r_stage.last_row <= (r_row == r_side_m1);
                r_stage.is_end   <= at_end;
                r_stage.value    <= i_value;
                r_stage.blocked  <= i_blocked;
            end else if (i_s1_fire) begin
                r_stage.valid <= 1'b0;
            end

            if (i_cfg_we) begin
                r_side_m1 <= n_side;
                r_col     <= n_side;
                r_row     <= n_side;
            end else if (accept) begin
                if (at_end) begin
                    r_col <= r_side_m1;
                    r_row <= r_side_m1;
                end else if (r_col == '0) begin
                    r_col <= r_side_m1;
                    r_row <= r_row - gmps_pkg::ColW'(1);
                end else begin
                    r_col <= r_col - gmps_pkg::ColW'(1);
                end
            end
        end
    end

endmodule

FILE: rtl/gmps_dp.sv
// Datapath: row store memory, right and diagonal neighbour registers and
// the per-cell merge. Depends on gmps_pkg.
`timescale 1ns / 1ps

module gmps_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  gmps_pkg::t_front i_front,
    input  gmps_pkg::t_stage i_stage,
    input  logic             i_s1_fire,
    output gmps_pkg::t_cell  o_cur
);

    gmps_pkg::t_cell r_mem [gmps_pkg::MaxSide];
    gmps_pkg::t_cell r_old;
    gmps_pkg::t_cell r_right;
    gmps_pkg::t_cell r_diag;
    gmps_pkg::t_cell n_cur;
    gmps_pkg::t_cell acc;
    logic [gmps_pkg::ScoreW:0] sum;

    // read for the next word is issued as it is taken; consecutive words
    // never share a column, so the write below cannot collide
    always_ff @(posedge i_clk) begin
        if (i_front.accept) begin
            r_old <= r_mem[i_front.col];
        end
        if (i_s1_fire) begin
            r_mem[i_stage.col] <= n_cur;
        end
    end

    always_comb begin
        acc = '0;
        if (i_stage.last_row && i_stage.last_col) begin
            acc.reach = 1'b1;
            acc.count = gmps_pkg::CountW'(1);
        end else if (!i_stage.blocked) begin
            if (!i_stage.last_col) begin
                acc = gmps_pkg::merge(acc, r_right);
            end
            if (!i_stage.last_row) begin
                acc = gmps_pkg::merge(acc, r_old);
            end
            if (!i_stage.last_row && !i_stage.last_col) begin
                acc = gmps_pkg::merge(acc, r_diag);
            end
        end
        sum   = {1'b0, acc.score} + (gmps_pkg::ScoreW + 1)'(i_stage.value);
        n_cur = acc;
        if (acc.reach) begin
            n_cur.score = sum[gmps_pkg::ScoreW] ? gmps_pkg::ScoreMax
                                                : sum[gmps_pkg::ScoreW-1:0];
        end
    end

    assign o_cur = n_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right <= '0;
            r_diag  <= '0;
        end else if (i_cfg_we) begin
            r_right <= '0;
            r_diag  <= '0;
        end else if (i_s1_fire) begin
            r_right <= n_cur;
            r_diag  <= r_old;
        end
    end

endmodule

FILE: verif/tb_grid_max_path_score_counter_unit.sv
// Testbench for grid_max_path_score_counter_unit: streams grids of cell words and
// checks each result word against a built-in path-score predictor.
// Depends on gmps_pkg, gmps_in_if / gmps_out_if and the unit itself.
`timescale 1ns / 1ps

module tb_grid_max_path_score_counter_unit;
    import gmps_pkg::*;

    localparam longint unsigned PathModulus = 64'd1000000007;
    localparam int              ResultLatency = 6;

    typedef struct packed {
        logic [ValW-1:0] value;
        logic            blk;
    } grid_word_t;

    typedef struct packed {
        logic [ScoreW-1:0] score;
        logic [CountW-1:0] count;
    } grid_result_t;

    typedef enum int {FILL_DIGITS, FILL_NIBBLES, FILL_FLAT} fill_mode_e;

    logic            i_clk;
    logic            i_rst_n;
    logic            cfg_we;
    logic [CfgW-1:0] cfg_wdata;

    gmps_in_if  cell_bus ();
    gmps_out_if res_bus ();

    grid_max_path_score_counter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (cell_bus),
        .o_out       (res_bus)
    );

    // stimulus and expectation stores
    grid_word_t   cell_words[$];
    grid_result_t pending_results[$];
    int           fail_count = 0;
    int           cells_queued;
    int           cells_taken = 0;
    int           src_gap;
    int           sink_stall;
    bit           hold_done;
    bit           src_idle_en;
    bit           snk_idle_en;

    // path-score predictor state
    logic [CfgW-1:0] side_reg;
    t_cell           row_mem[MaxSide];
    t_cell           right_nb;
    t_cell           diag_nb;
    int              col_pos;
    int              row_pos;

    function automatic int side_cells();
        int n;
        n = int'(side_reg);
        if (n < 2) n = 2;
        if (n > MaxSide) n = MaxSide;
        return n;
    endfunction

    function automatic void restart_grid();
        right_nb = '0;
        diag_nb  = '0;
        col_pos  = side_cells() - 1;
        row_pos  = side_cells() - 1;
    endfunction

    // best-of merge; equal scores add their counts mod the path modulus
    function automatic t_cell fold_in(input t_cell acc, input t_cell nb);
        longint unsigned sum;
        if (!nb.reach) return acc;
        if (!acc.reach || nb.score > acc.score) return nb;
        if (nb.score == acc.score) begin
            sum = longint'(acc.count) + longint'(nb.count);
            if (sum >= PathModulus) sum = sum - PathModulus;
            acc.count = CountW'(sum);
        end
        return acc;
    endfunction

    function automatic void advance_path_dp(input logic [ValW-1:0] v, input logic blk);
        int           n;
        bit           lc;
        bit           lr;
        int           s;
        t_cell        above;
        t_cell        cur;
        grid_result_t res;
        n     = side_cells();
        lc    = (col_pos == n - 1);
        lr    = (row_pos == n - 1);
        above = row_mem[col_pos];
        cur   = '0;
        if (lr && lc) begin
            // start word is always reachable, blocked or not
            cur.reach = 1'b1;
            cur.count = CountW'(1);
        end else if (!blk) begin
            if (!lc) cur = fold_in(cur, right_nb);
            if (!lr) cur = fold_in(cur, above);
            if (!lr && !lc) cur = fold_in(cur, diag_nb);
        end
        if (cur.reach) begin
            s         = int'(cur.score) + int'(v);
            cur.score = (s > int'(ScoreMax)) ? ScoreMax : ScoreW'(s);
        end
        diag_nb          = above;
        row_mem[col_pos] = cur;
        right_nb         = cur;
        if (row_pos == 0 && col_pos == 0) begin
            res = '0;
            if (cur.reach) begin
                res.score = cur.score;
                res.count = cur.count;
            end
            pending_results.push_back(res);
            restart_grid();
        end else if (col_pos == 0) begin
            col_pos = n - 1;
            row_pos = row_pos - 1;
        end else begin
            col_pos = col_pos - 1;
        end
    endfunction

    function automatic int idle_len(input bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(30, 90);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // time limit
    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    // driver: one word at a time from cell_words, random gap after each
    always @(posedge i_clk) begin : drive_words
        grid_word_t w;
        if (!i_rst_n) begin
            cell_bus.valid      <= 1'b0;
            cell_bus.cell_value <= '0;
            cell_bus.blocked    <= 1'b0;
            src_gap             <= 0;
        end else if (!cell_bus.valid || cell_bus.ready) begin
            if (src_gap != 0) begin
                cell_bus.valid <= 1'b0;
                src_gap        <= src_gap - 1;
            end else if (cell_words.size() != 0) begin
                w = cell_words.pop_front();
                cell_bus.valid      <= 1'b1;
                cell_bus.cell_value <= w.value;
                cell_bus.blocked    <= w.blk;
                src_gap             <= idle_len(src_idle_en);
            end else begin
                cell_bus.valid <= 1'b0;
            end
        end
    end

    // every accepted word advances the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && cell_bus.valid && cell_bus.ready) begin
            advance_path_dp(cell_bus.cell_value, cell_bus.blocked);
            cells_taken <= cells_taken + 1;
        end
    end

    // result sink: random stalls, plus one long hold-off while three
    // 2x2 grids are queued back to back
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            sink_stall    <= 0;
            hold_done     <= 1'b0;
        end else if (!hold_done && cells_taken >= 13) begin
            hold_done     <= 1'b1;
            sink_stall    <= 1000;
            res_bus.ready <= 1'b0;
        end else if (sink_stall != 0) begin
            sink_stall    <= sink_stall - 1;
            res_bus.ready <= 1'b0;
        end else begin
            res_bus.ready <= 1'b1;
            sink_stall    <= ($urandom_range(0, 5) == 0) ? idle_len(snk_idle_en) : 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_results
        grid_result_t want;
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result word score=%0d count=%0d", $time,
                         res_bus.best_score, res_bus.path_count);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (res_bus.best_score !== want.score) begin
                    $display("%0t: best_score expected %0d got %0d", $time,
                             want.score, res_bus.best_score);
                    fail_count++;
                end
                if (res_bus.path_count !== want.count) begin
                    $display("%0t: path_count expected %0d got %0d", $time,
                             want.count, res_bus.path_count);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_word(input logic [ValW-1:0] v, input logic blk);
        grid_word_t w;
        w.value = v;
        w.blk   = blk;
        cell_words.push_back(w);
        cells_queued++;
    endtask

    task automatic queue_grid(input int n, input int obst_pct, input fill_mode_e mode);
        int              k;
        int              total;
        logic [ValW-1:0] flat;
        logic [ValW-1:0] v;
        total = n * n;
        flat  = ValW'($urandom_range(0, 15));
        for (k = 0; k < total; k++) begin
            case (mode)
                FILL_DIGITS:  v = ValW'($urandom_range(0, 9));
                FILL_NIBBLES: v = ValW'($urandom_range(0, 15));
                default:      v = flat;
            endcase
            // start and end words usually carry zero
            if ((k == 0 || k == total - 1) && $urandom_range(0, 3) != 0) v = '0;
            push_word(v, $urandom_range(0, 99) < obst_pct);
        end
    endtask

    // wait until all words are taken and all results are back
    task automatic settle();
        while (cell_words.size() != 0 || cell_bus.valid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (ResultLatency) @(posedge i_clk);
    endtask

    task automatic set_side(input logic [CfgW-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        side_reg  = v;
        restart_grid();
    endtask

    initial begin : stimulus
        int         k;
        int         n;
        int         reps;
        int         stop_at;
        int         sel;
        logic [7:0] sv;
        fill_mode_e mode;

        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        cells_queued        = 0;
        src_idle_en         = 1'b1;
        snk_idle_en         = 1'b1;
        side_reg            = CfgW'(2);
        for (k = 0; k < MaxSide; k++) row_mem[k] = '0;
        restart_grid();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 2x2 grids, order: start, left of start, above start, end
        push_word(4'd0, 1'b0); push_word(4'd9, 1'b0);
        push_word(4'd9, 1'b0); push_word(4'd0, 1'b0);
        set_side(8'd0);    // clamps to 2
        // blocked start with a value above nine
        push_word(4'd15, 1'b1); push_word(4'd15, 1'b0);
        push_word(4'd3, 1'b0);  push_word(4'd0, 1'b0);
        // only the diagonal step remains
        push_word(4'd0, 1'b0); push_word(4'd1, 1'b1);
        push_word(4'd1, 1'b1); push_word(4'd0, 1'b0);
        set_side(8'd1);    // clamps to 2
        // end blocked: no path
        push_word(4'd0, 1'b0); push_word(4'd0, 1'b0);
        push_word(4'd0, 1'b0); push_word(4'd0, 1'b1);
        // three tied paths
        push_word(4'd0, 1'b0); push_word(4'd0, 1'b0);
        push_word(4'd0, 1'b0); push_word(4'd0, 1'b0);
        push_word(4'd15, 1'b0); push_word(4'd15, 1'b0);
        push_word(4'd15, 1'b0); push_word(4'd15, 1'b0);

        // grid in progress dropped by a size write
        set_side(8'd3);
        for (k = 0; k < 5; k++) begin
            push_word(ValW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end
        set_side(8'd128);
        for (k = 0; k < 200; k++) push_word(ValW'($urandom_range(0, 9)), $urandom_range(0, 9) == 0);

        // side above the largest clamps to it; partial grid into the second row
        set_side(8'd255);
        for (k = 0; k < 130; k++) push_word(ValW'($urandom_range(0, 15)), $urandom_range(0, 7) == 0);

        // flat values on an open grid: tie counts wrap the path modulus when the value is zero
        set_side(8'd16);
        queue_grid(16, 0, FILL_FLAT);

        stop_at = cells_queued + 840;
        while (cells_queued < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) sv = CfgW'($urandom_range(0, 1));
            else if (sel < 85) sv = CfgW'($urandom_range(2, 6));
            else sv = CfgW'($urandom_range(7, 16));
            src_idle_en = ($urandom_range(0, 4) != 0);
            snk_idle_en = ($urandom_range(0, 4) != 0);
            set_side(sv);
            n    = side_cells();
            reps = $urandom_range(1, 4);
            for (k = 0; k < reps; k++) begin
                case ($urandom_range(0, 2))
                    0:       mode = FILL_DIGITS;
                    1:       mode = FILL_NIBBLES;
                    default: mode = FILL_FLAT;
                endcase
                sel = $urandom_range(0, 9);
                queue_grid(n, (sel < 3) ? 0 : (sel < 6) ? 8 : (sel < 9) ? 25 : 65, mode);
            end
            if ($urandom_range(0, 9) == 0) begin
                sel = $urandom_range(1, n * n - 1);
                for (k = 0; k < sel; k++) begin
                    push_word(ValW'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
                end
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
